@@ sv/rws_pkg.sv @@
// Shared constants and types for the roulette wheel selector.
`default_nettype none
package rws_pkg;

	localparam int MAX_POPULATION = 1024;
	localparam int WEIGHT_BITS    = 16;
	localparam int IDX_W          = $clog2(MAX_POPULATION);
	localparam int CNT_W          = IDX_W + 1;
	localparam int TOTAL_W        = 26;
	localparam int RND_W          = 31;
	localparam int BEST_W         = WEIGHT_BITS + 1;
	localparam int RND_CNT_W      = $clog2(RND_W);

	typedef enum logic [1:0] {
		ACT_BEGIN  = 2'd0,
		ACT_LOAD   = 2'd1,
		ACT_SELECT = 2'd2
	} action_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_MOD,
		ST_WALK
	} state_t;

endpackage
`default_nettype wire

@@ sv/rws_ram.sv @@
// Generic simple dual-port RAM with registered read.
`default_nettype none
module rws_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 1024
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule
`default_nettype wire

@@ sv/rws_mod.sv @@
// Bit-serial restoring modulo unit: random value modulo running total.
`default_nettype none
module rws_mod
	import rws_pkg::*;
(
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               start,
	input  wire logic [RND_W-1:0]   dividend,
	input  wire logic [TOTAL_W-1:0] divisor,
	output logic                    done,
	output logic      [TOTAL_W-1:0] remainder
);

	logic [TOTAL_W-1:0]   rem_q;
	logic [RND_W-1:0]     dvd_q;
	logic [RND_CNT_W-1:0] cnt_q;
	logic                 run_q;
	logic                 done_q;
	logic [TOTAL_W:0]     trial;
	logic [TOTAL_W:0]     diff;
	logic [TOTAL_W-1:0]   rem_d;

	// remainder stays below divisor, so one compare-subtract per bit suffices
	always_comb begin
		trial = {rem_q, dvd_q[RND_W-1]};
		diff  = trial - {1'b0, divisor};
		if (trial >= {1'b0, divisor}) begin
			rem_d = diff[TOTAL_W-1:0];
		end else begin
			rem_d = trial[TOTAL_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= RND_CNT_W'(RND_W - 1);
			end else if (run_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == '0) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			dvd_q <= dividend;
		end else if (run_q) begin
			rem_q <= rem_d;
			dvd_q <= {dvd_q[RND_W-2:0], 1'b0};
		end
	end

	assign done      = done_q;
	assign remainder = rem_q;

endmodule
`default_nettype wire

@@ sv/roulette_wheel_selector.sv @@
// Roulette wheel selector: sequencer, weight store and running totals.
//
// Begin generation, load weight and unknown actions finish at once: done
// pulses in the cycle after start and busy stays low. A select first runs
// the one-bit-per-cycle modulo unit, then walks the weight RAM one entry a
// cycle through its single read port, ending at the first hit or the last
// active individual. busy falls with done, so the next request is taken
// no earlier than that. Results are shown for exactly one cycle under
// done; the receiver cannot hold them off, so sample on done.
// total_weight, best_weight and best_index hold until the next accepted
// request.
`default_nettype none
module roulette_wheel_selector
	import rws_pkg::*;
(
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     population_count_we,
	input  wire logic [CNT_W-1:0]         population_count,
	input  wire logic                     start,
	output logic                          busy,
	input  wire logic [1:0]               action,
	input  wire logic [IDX_W-1:0]         weight_index,
	input  wire logic [15:0]              weight_value,
	input  wire logic [RND_W-1:0]         random_value,
	output logic                          done,
	output logic      [IDX_W-1:0]         selected_index,
	output logic      [TOTAL_W-1:0]       total_weight,
	output logic signed [BEST_W-1:0]      best_weight,
	output logic      [IDX_W-1:0]         best_index
);

	state_t                    state_q, state_d;
	action_t                   act;
	logic                      accept;
	logic                      mod_start;
	logic                      mod_done;
	logic [TOTAL_W-1:0]        mod_rem;
	logic                      walk_end;

	logic [CNT_W-1:0]          pc_q;
	logic [CNT_W-1:0]          pc_m1;
	logic [IDX_W-1:0]          last_idx;

	logic [TOTAL_W-1:0]        total_q;
	logic signed [BEST_W-1:0]  best_q;
	logic [IDX_W-1:0]          best_idx_q;
	logic [IDX_W-1:0]          sel_q;
	logic                      done_q;

	logic [WEIGHT_BITS-1:0]    w_in;
	logic [TOTAL_W:0]          sum;

	logic [CNT_W-1:0]          addr_q;
	logic                      issue;
	logic                      rd_vld_s1;
	logic [IDX_W-1:0]          cmp_idx_s1;
	logic [TOTAL_W-1:0]        left_q;
	logic [WEIGHT_BITS-1:0]    rdata;
	logic                      hit;

	assign act    = action_t'(action);
	assign busy   = (state_q != ST_IDLE);
	assign accept = start && !busy;
	assign w_in   = weight_value[WEIGHT_BITS-1:0];
	assign sum    = {1'b0, total_q} + (TOTAL_W+1)'(w_in);

	// effective population clamped to 1..MAX_POPULATION
	assign pc_m1 = pc_q - 1'b1;
	always_comb begin
		if (pc_q == '0) begin
			last_idx = '0;
		end else if (pc_q > CNT_W'(MAX_POPULATION)) begin
			last_idx = IDX_W'(MAX_POPULATION - 1);
		end else begin
			last_idx = pc_m1[IDX_W-1:0];
		end
	end

	assign issue = (state_q == ST_WALK) && (addr_q <= {1'b0, last_idx});
	assign hit   = left_q < TOTAL_W'(rdata);

	rws_mod u_mod (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (mod_start),
		.dividend  (random_value),
		.divisor   (total_q),
		.done      (mod_done),
		.remainder (mod_rem)
	);

	rws_ram #(
		.WIDTH (WEIGHT_BITS),
		.DEPTH (MAX_POPULATION)
	) u_weights (
		.clk   (clk),
		.we    (accept && (act == ACT_LOAD)),
		.waddr (weight_index),
		.wdata (w_in),
		.raddr (addr_q[IDX_W-1:0]),
		.rdata (rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		mod_start = 1'b0;
		walk_end  = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (start && (act == ACT_SELECT)) begin
					state_d   = ST_MOD;
					mod_start = 1'b1;
				end
			end
			ST_MOD: begin
				if (mod_done) begin
					state_d = ST_WALK;
				end
			end
			ST_WALK: begin
				if (rd_vld_s1 && (hit || (cmp_idx_s1 == last_idx))) begin
					state_d  = ST_IDLE;
					walk_end = 1'b1;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q       <= CNT_W'(MAX_POPULATION);
			total_q    <= TOTAL_W'(1);
			best_q     <= '1;
			best_idx_q <= '0;
			done_q     <= 1'b0;
			sel_q      <= '0;
			rd_vld_s1  <= 1'b0;
		end else begin
			if (population_count_we) begin
				pc_q <= population_count;
			end
			done_q <= (accept && (act != ACT_SELECT)) || walk_end;
			if (accept) begin
				sel_q <= '0;
				case (act)
					ACT_BEGIN: begin
						total_q <= TOTAL_W'(1);
					end
					ACT_LOAD: begin
						total_q <= sum[TOTAL_W] ? '1 : sum[TOTAL_W-1:0];
						if ($signed({1'b0, w_in}) > best_q) begin
							best_q     <= $signed({1'b0, w_in});
							best_idx_q <= weight_index;
						end
					end
					default: begin
					end
				endcase
			end
			if (walk_end) begin
				sel_q <= cmp_idx_s1;
			end
			rd_vld_s1 <= mod_done ? 1'b0 : issue;
		end
	end

	// walk: address runs one entry ahead of the compare
	always_ff @(posedge clk) begin
		if (mod_done) begin
			left_q <= mod_rem;
			addr_q <= '0;
		end else begin
			if (issue) begin
				addr_q <= addr_q + 1'b1;
			end
			cmp_idx_s1 <= addr_q[IDX_W-1:0];
			if ((state_q == ST_WALK) && rd_vld_s1 && !hit) begin
				left_q <= left_q - TOTAL_W'(rdata);
			end
		end
	end

	assign done           = done_q;
	assign selected_index = sel_q;
	assign total_weight   = total_q;
	assign best_weight    = best_q;
	assign best_index     = best_idx_q;

	a_mod_done_in_mod: assert property (@(posedge clk) disable iff (!arst_n)
		mod_done |-> (state_q == ST_MOD))
		else $error("modulo result outside modulo phase");

	a_total_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		total_q != '0)
		else $error("running total reached zero");

	a_busy_from_start: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(busy) |-> $past(start))
		else $error("busy rose without a request");

endmodule
`default_nettype wire

@@ tb/sv/roulette_wheel_selector_test.sv @@
// Self-checking testbench for the roulette wheel selector.
`timescale 1ns / 1ps
module roulette_wheel_selector_test
	import rws_pkg::*;
();

	localparam logic [1:0]  ACT_UNKNOWN  = 2'd3;
	localparam int unsigned TOTAL_CAP    = (1 << TOTAL_W) - 1;
	localparam int unsigned WEIGHT_MAX   = (1 << WEIGHT_BITS) - 1;
	localparam int          LIMIT_CYCLES = 8_000_000;

	typedef struct {
		logic [1:0]         act;
		logic [IDX_W-1:0]   idx;
		logic [15:0]        w;
		logic [RND_W-1:0]   rnd;
	} wheel_request_t;

	typedef struct {
		logic [IDX_W-1:0]          sel;
		logic [TOTAL_W-1:0]        total;
		logic signed [BEST_W-1:0]  best_w;
		logic [IDX_W-1:0]          best_i;
	} wheel_outcome_t;

	class wheel_scoreboard;
		logic [WEIGHT_BITS-1:0]    fitness [MAX_POPULATION];
		bit                        loaded  [MAX_POPULATION];
		logic [TOTAL_W:0]          total;
		logic signed [BEST_W-1:0]  best_w;
		logic [IDX_W-1:0]          best_i;
		logic [CNT_W-1:0]          pop;
		wheel_outcome_t            pending_outcomes [$];
		int                        failures;

		function new();
			for (int i = 0; i < MAX_POPULATION; i++) begin
				fitness[i] = '0;
				loaded[i] = 1'b0;
			end
			total = (TOTAL_W+1)'(1);
			best_w = BEST_W'(-1);
			best_i = '0;
			pop = CNT_W'(MAX_POPULATION);
			failures = 0;
		endfunction

		function int unsigned live_count();
			if (pop == 0)
				return 1;
			if (pop > MAX_POPULATION)
				return MAX_POPULATION;
			return pop;
		endfunction

		// walk the table; gap is the first never-loaded entry the walk reads, or -1
		function void spin(input logic [RND_W-1:0] rnd, output logic [IDX_W-1:0] pick,
				output int gap);
			int unsigned n;
			int unsigned i;
			longint unsigned left;
			bit hit;
			n = live_count();
			left = longint'(rnd) % longint'(total);
			gap = -1;
			hit = 1'b0;
			pick = IDX_W'(n - 1);
			for (i = 0; i < n && !hit; i++) begin
				if (!loaded[i] && gap < 0)
					gap = int'(i);
				if (left < fitness[i]) begin
					pick = IDX_W'(i);
					hit = 1'b1;
				end else begin
					left -= fitness[i];
				end
			end
		endfunction

		function int spin_gap(input logic [RND_W-1:0] rnd);
			logic [IDX_W-1:0] pick;
			int gap;
			spin(rnd, pick, gap);
			return gap;
		endfunction

		function void note_request(input wheel_request_t r);
			wheel_outcome_t e;
			logic [IDX_W-1:0] pick;
			int gap;
			e.sel = '0;
			case (r.act)
				ACT_BEGIN: total = (TOTAL_W+1)'(1);
				ACT_LOAD: begin
					fitness[r.idx] = r.w[WEIGHT_BITS-1:0];
					loaded[r.idx] = 1'b1;
					total = total + r.w[WEIGHT_BITS-1:0];
					if (total > TOTAL_CAP)
						total = (TOTAL_W+1)'(TOTAL_CAP);
					// best only moves on a strictly greater weight
					if ($signed({1'b0, r.w[WEIGHT_BITS-1:0]}) > best_w) begin
						best_w = $signed({1'b0, r.w[WEIGHT_BITS-1:0]});
						best_i = r.idx;
					end
				end
				ACT_SELECT: begin
					spin(r.rnd, pick, gap);
					e.sel = pick;
				end
				default: ;
			endcase
			e.total = total[TOTAL_W-1:0];
			e.best_w = best_w;
			e.best_i = best_i;
			pending_outcomes.insert(pending_outcomes.size(), e);
		endfunction

		function void check_outcome(input wheel_outcome_t got);
			wheel_outcome_t want;
			if (pending_outcomes.size() == 0) begin
				$error("result with no request outstanding");
				failures++;
				return;
			end
			want = pending_outcomes.pop_front();
			if (got.sel !== want.sel) begin
				$error("selected_index: expected %0d, got %0d", want.sel, got.sel);
				failures++;
			end
			if (got.total !== want.total) begin
				$error("total_weight: expected %0d, got %0d", want.total, got.total);
				failures++;
			end
			if (got.best_w !== want.best_w) begin
				$error("best_weight: expected %0d, got %0d", want.best_w, got.best_w);
				failures++;
			end
			if (got.best_i !== want.best_i) begin
				$error("best_index: expected %0d, got %0d", want.best_i, got.best_i);
				failures++;
			end
		endfunction
	endclass

	logic                      clk = 1'b0;
	logic                      arst_n = 1'b0;
	logic                      population_count_we = 1'b0;
	logic [CNT_W-1:0]          population_count = '0;
	logic                      start = 1'b0;
	logic [1:0]                action = '0;
	logic [IDX_W-1:0]          weight_index = '0;
	logic [15:0]               weight_value = '0;
	logic [RND_W-1:0]          random_value = '0;
	logic                      busy;
	logic                      done;
	logic [IDX_W-1:0]          selected_index;
	logic [TOTAL_W-1:0]        total_weight;
	logic signed [BEST_W-1:0]  best_weight;
	logic [IDX_W-1:0]          best_index;

	wheel_scoreboard sb;
	wheel_outcome_t  seen;
	int              burst_left = 0;
	int              cycle_count = 0;

	roulette_wheel_selector dut (
		.clk                 (clk),
		.arst_n              (arst_n),
		.population_count_we (population_count_we),
		.population_count    (population_count),
		.start               (start),
		.busy                (busy),
		.action              (action),
		.weight_index        (weight_index),
		.weight_value        (weight_value),
		.random_value        (random_value),
		.done                (done),
		.selected_index      (selected_index),
		.total_weight        (total_weight),
		.best_weight         (best_weight),
		.best_index          (best_index)
	);

	always #6 clk = ~clk;

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == LIMIT_CYCLES) begin
			$display("FAIL roulette_wheel_selector");
			$finish;
		end
	end

	// results live for one cycle only, so take them at the edge that ends it
	always @(posedge clk) begin
		if (arst_n && done) begin
			seen.sel = selected_index;
			seen.total = total_weight;
			seen.best_w = best_weight;
			seen.best_i = best_index;
			sb.check_outcome(seen);
		end
	end

	function automatic wheel_request_t compose_request(input logic [1:0] act,
			input logic [IDX_W-1:0] idx, input logic [15:0] w, input logic [RND_W-1:0] rnd);
		wheel_request_t r;
		r.act = act;
		r.idx = idx;
		r.w = w;
		r.rnd = rnd;
		return r;
	endfunction

	function automatic logic [15:0] pick_weight();
		case ($urandom_range(0, 9))
			0, 1:    return '0;
			2:       return 16'(WEIGHT_MAX);
			3, 4:    return 16'($urandom_range(1, 15));
			default: return 16'($urandom);
		endcase
	endfunction

	function automatic logic [RND_W-1:0] pick_spin();
		case ($urandom_range(0, 3))
			0:       return RND_W'($urandom);
			1:       return RND_W'($urandom_range(0, sb.total - 1));
			2:       return RND_W'(sb.total - 1);
			default: return RND_W'($urandom_range(0, 255));
		endcase
	endfunction

	function automatic wheel_request_t random_request();
		wheel_request_t r;
		int unsigned roll;
		int gap;
		r = compose_request(2'($urandom), IDX_W'($urandom), 16'($urandom), RND_W'($urandom));
		roll = $urandom_range(0, 99);
		if (roll < 8)
			r.act = ACT_BEGIN;
		else if (roll < 50)
			r.act = ACT_LOAD;
		else if (roll < 92)
			r.act = ACT_SELECT;
		else
			r.act = ACT_UNKNOWN;
		if (r.act == ACT_LOAD) begin
			if ($urandom_range(0, 3) != 0)
				r.idx = IDX_W'($urandom_range(0, sb.live_count() - 1));
			r.w = pick_weight();
		end
		if (r.act == ACT_SELECT) begin
			gap = 0;
			for (int k = 0; k < 3 && gap >= 0; k++) begin
				r.rnd = pick_spin();
				gap = sb.spin_gap(r.rnd);
			end
			// the walk would touch an empty slot: fill that slot instead
			if (gap >= 0) begin
				r.act = ACT_LOAD;
				r.idx = IDX_W'(gap);
				r.w = pick_weight();
			end
		end
		return r;
	endfunction

	task automatic issue(input wheel_request_t r);
		int idle;
		if (burst_left == 0) begin
			idle = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
			repeat (idle) begin
				start <= 1'b0;
				@(posedge clk);
			end
			burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 60)
					: $urandom_range(1, 10);
		end
		burst_left--;
		start <= 1'b1;
		action <= r.act;
		weight_index <= r.idx;
		weight_value <= r.w;
		random_value <= r.rnd;
		do
			@(posedge clk);
		while (busy !== 1'b0);
		sb.note_request(r);
	endtask

	task automatic drain();
		start <= 1'b0;
		@(posedge clk);
		while (sb.pending_outcomes.size() != 0)
			@(posedge clk);
	endtask

	task automatic reconfigure(input logic [CNT_W-1:0] v);
		drain();
		repeat (4) @(posedge clk);
		population_count_we <= 1'b1;
		population_count <= v;
		@(posedge clk);
		sb.pop = v;
		population_count_we <= 1'b0;
	endtask

	task automatic run_random(input int count);
		repeat (count) issue(random_request());
	endtask

	task automatic directed_checks();
		reconfigure(CNT_W'(4));
		// reset state reported by an unknown action
		issue(compose_request(ACT_UNKNOWN, '1, '1, '1));
		issue(compose_request(ACT_BEGIN, '0, '0, '0));
		issue(compose_request(ACT_LOAD, 10'd0, 16'd0, RND_W'($urandom)));
		issue(compose_request(ACT_LOAD, 10'd1, 16'd0, RND_W'($urandom)));
		issue(compose_request(ACT_LOAD, 10'd2, 16'hFFFF, RND_W'($urandom)));
		// equal weight must not take over the best
		issue(compose_request(ACT_LOAD, 10'd3, 16'hFFFF, RND_W'($urandom)));
		// beyond the population, still counted
		issue(compose_request(ACT_LOAD, 10'd1023, 16'd5, RND_W'($urandom)));
		issue(compose_request(ACT_SELECT, '0, '0, '0));
		issue(compose_request(ACT_SELECT, '0, '0, '1));
		// remainder past every active weight: falls back to the last individual
		issue(compose_request(ACT_SELECT, '0, '0, RND_W'(sb.total - 1)));
		issue(compose_request(ACT_UNKNOWN, IDX_W'($urandom), 16'($urandom), RND_W'($urandom)));
		// new generation keeps the table and the best
		issue(compose_request(ACT_BEGIN, IDX_W'($urandom), 16'($urandom), RND_W'($urandom)));
		issue(compose_request(ACT_SELECT, '0, '0, RND_W'(12345)));
		issue(compose_request(ACT_LOAD, 10'd0, 16'd1, '0));
		issue(compose_request(ACT_SELECT, '0, '0, RND_W'(1)));
		issue(compose_request(ACT_LOAD, 10'd1, 16'd7, '0));
		issue(compose_request(ACT_SELECT, '0, '0, RND_W'(2)));
	endtask

	initial begin
		sb = new();
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		directed_checks();
		reconfigure(CNT_W'(2));
		run_random(70);
		reconfigure(CNT_W'(0));
		run_random(60);
		reconfigure(CNT_W'(1));
		run_random(60);
		reconfigure(CNT_W'(6));
		run_random(70);
		reconfigure(CNT_W'(13));
		run_random(80);
		reconfigure('1);
		run_random(120);
		reconfigure(CNT_W'(3));
		run_random(80);

		drain();
		repeat (1100) @(posedge clk);
		if (sb.failures == 0)
			$display("PASS roulette_wheel_selector");
		else
			$display("FAIL roulette_wheel_selector");
		$finish;
	end

endmodule
